// ===== sv/owt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owt_pkg
// Types and constants shared by the single-wire temperature sensor master.
// ----------------------------------------------------------------------------
package owt_pkg;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 20;
    localparam int SHORT_WIDTH    = 10;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PRESENCE      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SLOT          = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WRITE_RECOVER = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SAMPLE        = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_READ_RECOVER  = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CONVERT_WAIT  = 3'd6;

    // opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CONVERT = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_CONV_RD = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_NO_PRES  = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    // bus commands
    localparam logic [7:0] CMD_SKIP     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    // byte_step values
    localparam logic [2:0] STEP_CMD     = 3'd1;
    localparam logic [2:0] STEP_LOW_RD  = 3'd2;
    localparam logic [2:0] STEP_HIGH_RD = 3'd3;

    localparam logic signed [7:0] TEMP_SCALE = 8'sd100;
    localparam int                TEMP_FRAC  = 4;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_PRES  = 4'd2,
        PH_RST_TAIL  = 4'd3,
        PH_WR_SLOT   = 4'd4,
        PH_WR_REC    = 4'd5,
        PH_RD_SLOT   = 4'd6,
        PH_RD_REC    = 4'd7,
        PH_CONV_WAIT = 4'd8
    } t_phase;

    typedef struct packed {
        logic [SHORT_WIDTH-1:0]    reset_low;
        logic [SHORT_WIDTH-1:0]    presence;
        logic [SHORT_WIDTH-1:0]    slot;
        logic [SHORT_WIDTH-1:0]    write_recover;
        logic [SHORT_WIDTH-1:0]    sample;
        logic [SHORT_WIDTH-1:0]    read_recover;
        logic [CFG_DATA_WIDTH-1:0] convert_wait;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic [2:0]         bit_index;
        logic [2:0]         byte_step;
        logic [7:0]         shift_byte;
        logic [7:0]         low_byte;
        logic [1:0]         operation;
        logic signed [15:0] temperature;
        logic [1:0]         last_status;
    } t_seq_state;

    typedef struct packed {
        logic               drive_low;
        logic               busy;
        logic               done;
        logic [1:0]         status;
        logic signed [15:0] temperature_centi;
    } t_result;

endpackage

// ===== sv/owt_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owt_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module owt_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [owt_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [owt_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_wdata,
    output owt_pkg::t_cfg                        o_cfg
);
    import owt_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESET_LOW:     n_cfg.reset_low     = i_cfg_wdata[SHORT_WIDTH-1:0];
                CFG_PRESENCE:      n_cfg.presence      = i_cfg_wdata[SHORT_WIDTH-1:0];
                CFG_SLOT:          n_cfg.slot          = i_cfg_wdata[SHORT_WIDTH-1:0];
                CFG_WRITE_RECOVER: n_cfg.write_recover = i_cfg_wdata[SHORT_WIDTH-1:0];
                CFG_SAMPLE:        n_cfg.sample        = i_cfg_wdata[SHORT_WIDTH-1:0];
                CFG_READ_RECOVER:  n_cfg.read_recover  = i_cfg_wdata[SHORT_WIDTH-1:0];
                CFG_CONVERT_WAIT:  n_cfg.convert_wait  = i_cfg_wdata;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= 10'd480;
            r_cfg.presence      <= 10'd60;
            r_cfg.slot          <= 10'd60;
            r_cfg.write_recover <= 10'd1;
            r_cfg.sample        <= 10'd10;
            r_cfg.read_recover  <= 10'd50;
            r_cfg.convert_wait  <= 20'd750000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/owt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owt_seq
// Next-state logic of the bus sequencer for one beat, and its result.
// ----------------------------------------------------------------------------
module owt_seq #(
    parameter int TIMER_WIDTH = 20
) (
    input  logic [1:0]              i_opcode,
    input  logic                    i_line,
    input  owt_pkg::t_seq_state     i_state,
    input  logic [TIMER_WIDTH-1:0]  i_tick,
    input  owt_pkg::t_cfg           i_cfg,
    output owt_pkg::t_seq_state     o_state,
    output logic [TIMER_WIDTH-1:0]  o_tick,
    output owt_pkg::t_result        o_result
);
    import owt_pkg::*;

    localparam int CW = (TIMER_WIDTH > CFG_DATA_WIDTH) ? TIMER_WIDTH : CFG_DATA_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    t_seq_state         ns;
    logic [TIMER_WIDTH-1:0] nt;
    logic [TIMER_WIDTH-1:0] tick_inc;
    logic [CW-1:0]      dur;
    logic               elapsed;
    logic               done;
    logic               rejected;
    logic signed [15:0] raw;
    logic signed [23:0] prod;
    logic signed [23:0] scaled;
    logic [2:0]         step_inc;

    assign raw    = $signed({i_state.shift_byte, i_state.low_byte});
    assign prod   = raw * TEMP_SCALE;
    // arithmetic shift floors, as required
    assign scaled = prod >>> TEMP_FRAC;

    assign tick_inc = (i_tick != TMAX) ? i_tick + 1'b1 : i_tick;
    assign step_inc = i_state.byte_step + 3'd1;

    always_comb begin
        unique case (i_state.phase)
            PH_RST_LOW, PH_RST_TAIL: dur = CW'(i_cfg.reset_low);
            PH_RST_PRES:             dur = CW'(i_cfg.presence);
            PH_WR_SLOT:              dur = CW'(i_cfg.slot);
            PH_WR_REC:               dur = CW'(i_cfg.write_recover);
            PH_RD_SLOT:              dur = CW'(i_cfg.sample);
            PH_RD_REC:               dur = CW'(i_cfg.read_recover);
            PH_CONV_WAIT:            dur = CW'(i_cfg.convert_wait);
            default:                 dur = '0;
        endcase
    end

    assign elapsed = (CW'(tick_inc) >= dur) || (tick_inc == TMAX);

    always_comb begin
        ns       = i_state;
        nt       = i_tick;
        done     = 1'b0;
        rejected = 1'b0;
        if (i_opcode == OP_TICK) begin
            if (i_state.phase != PH_IDLE) begin
                nt = tick_inc;
                unique case (i_state.phase)
                    PH_RST_LOW: begin
                        if (elapsed) begin
                            ns.phase = PH_RST_PRES;
                            nt       = '0;
                        end
                    end
                    PH_RST_PRES: begin
                        if (elapsed) begin
                            nt = '0;
                            if (i_line) begin
                                ns.phase       = PH_IDLE;
                                ns.last_status = ST_NO_PRES;
                                done           = 1'b1;
                            end else begin
                                ns.phase = PH_RST_TAIL;
                            end
                        end
                    end
                    PH_RST_TAIL: begin
                        if (elapsed) begin
                            ns.byte_step  = '0;
                            ns.shift_byte = CMD_SKIP;
                            ns.bit_index  = '0;
                            ns.phase      = PH_WR_SLOT;
                            nt            = '0;
                        end
                    end
                    PH_WR_SLOT: begin
                        if (elapsed) begin
                            ns.phase = PH_WR_REC;
                            nt       = '0;
                        end
                    end
                    PH_WR_REC: begin
                        if (elapsed) begin
                            nt = '0;
                            if (i_state.bit_index != 3'd7) begin
                                ns.bit_index = i_state.bit_index + 3'd1;
                                ns.phase     = PH_WR_SLOT;
                            end else begin
                                ns.byte_step = step_inc;
                                if (step_inc == STEP_CMD) begin
                                    ns.shift_byte = (i_state.operation == OP_READ) ?
                                                    CMD_READ_PAD : CMD_CONVERT;
                                    ns.bit_index  = '0;
                                    ns.phase      = PH_WR_SLOT;
                                end else if (i_state.operation == OP_READ) begin
                                    ns.shift_byte = '0;
                                    ns.bit_index  = '0;
                                    ns.phase      = PH_RD_SLOT;
                                end else if (i_state.operation == OP_CONV_RD) begin
                                    ns.operation = OP_READ;
                                    ns.phase     = PH_CONV_WAIT;
                                end else begin
                                    ns.phase       = PH_IDLE;
                                    ns.last_status = ST_OK;
                                    done           = 1'b1;
                                end
                            end
                        end
                    end
                    PH_RD_SLOT: begin
                        if (elapsed) begin
                            ns.shift_byte[i_state.bit_index] =
                                i_state.shift_byte[i_state.bit_index] | i_line;
                            ns.phase = PH_RD_REC;
                            nt       = '0;
                        end
                    end
                    PH_RD_REC: begin
                        if (elapsed) begin
                            nt = '0;
                            if (i_state.bit_index != 3'd7) begin
                                ns.bit_index = i_state.bit_index + 3'd1;
                                ns.phase     = PH_RD_SLOT;
                            end else if (i_state.byte_step == STEP_LOW_RD) begin
                                ns.low_byte   = i_state.shift_byte;
                                ns.byte_step  = STEP_HIGH_RD;
                                ns.shift_byte = '0;
                                ns.bit_index  = '0;
                                ns.phase      = PH_RD_SLOT;
                            end else begin
                                ns.temperature = scaled[15:0];
                                ns.phase       = PH_IDLE;
                                ns.last_status = ST_OK;
                                done           = 1'b1;
                            end
                        end
                    end
                    PH_CONV_WAIT: begin
                        if (elapsed) begin
                            ns.phase = PH_RST_LOW;
                            nt       = '0;
                        end
                    end
                    default: begin
                        ns.phase = PH_IDLE;
                        nt       = '0;
                    end
                endcase
            end
        end else if (i_state.phase != PH_IDLE) begin
            rejected = 1'b1;
        end else begin
            ns.operation = i_opcode;
            ns.byte_step = '0;
            ns.phase     = PH_RST_LOW;
            nt           = '0;
        end
    end

    always_comb begin
        o_result.drive_low = 1'b0;
        unique case (ns.phase)
            PH_RST_LOW: o_result.drive_low = 1'b1;
            PH_WR_SLOT: o_result.drive_low = (nt == '0) ? 1'b1 : ~ns.shift_byte[ns.bit_index];
            PH_RD_SLOT: o_result.drive_low = (nt == '0);
            default:    o_result.drive_low = 1'b0;
        endcase
        o_result.busy = (ns.phase != PH_IDLE);
        o_result.done = done;
        if (rejected) begin
            o_result.status = ST_REJECTED;
        end else if (ns.phase != PH_IDLE) begin
            o_result.status = ST_RUNNING;
        end else begin
            o_result.status = ns.last_status;
        end
        o_result.temperature_centi = ns.temperature;
    end

    assign o_state = ns;
    assign o_tick  = nt;

endmodule

// ===== sv/onewire_temp_sensor_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_temp_sensor_master
// Single-wire bus master running reset, skip-ROM, convert and scratchpad
// read sequences for one temperature sensor.
// ----------------------------------------------------------------------------
// Every input beat, a microsecond tick or a command, yields exactly one
// result beat. The sequencer state and a result register are updated at
// the edge that accepts it, so with the output taken every cycle the block
// sustains one beat per cycle, and the result appears on the output in the
// cycle after acceptance. The output register lets a new beat be accepted
// in the same cycle the waiting result is taken. The user must write timing
// registers via the cfg port only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module onewire_temp_sensor_master #(
    parameter int TIMER_WIDTH = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [owt_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [owt_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [0] line_level
    input  logic [1:0]                          s_axis_tuser,  // [1:0] opcode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
    // [20:5] temperature_centi
    output logic [23:0]                         m_axis_tdata
);
    import owt_pkg::*;

    t_cfg                   cfg;
    t_seq_state             r_state;
    t_seq_state             n_state;
    logic [TIMER_WIDTH-1:0] r_tick;
    logic [TIMER_WIDTH-1:0] n_tick;
    t_result                n_result;
    t_result                r_result;
    logic                   r_out_valid;
    logic                   accept;

    owt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    owt_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_opcode (s_axis_tuser),
        .i_line   (s_axis_tdata[0]),
        .i_state  (r_state),
        .i_tick   (r_tick),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_tick   (n_tick),
        .o_result (n_result)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_IDLE, temperature: '0, default: '0};
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_result.temperature_centi, r_result.status,
                            r_result.done, r_result.busy, r_result.drive_low};

endmodule
